// ===== hdl/srle_pkg.sv =====
package srle_pkg;

  localparam int ACC_W   = 32;
  localparam int TICK_W  = 20;
  localparam int DEV_W   = 6;
  localparam int ADDR_W  = 9;
  localparam int VAL_W   = 8;
  localparam int WAIT_W  = 24;
  localparam int BYTE_W  = 8;
  localparam int GRP_W   = 7;
  localparam int IN_DATA_W = 48;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10000);
  localparam logic [ACC_W-1:0]  ACC_MAX    = '1;

  localparam logic [BYTE_W-1:0] SYNC_ONE  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_MANY = 8'hFE;
  localparam logic [BYTE_W-1:0] END_CODE  = 8'hFD;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_WAIT   = 2'd1,
    REQ_END    = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SYNC_HEAD,
    ST_SYNC_GRP,
    ST_DEV,
    ST_ADDR,
    ST_DATA,
    ST_END
  } state_t;

endpackage

// ===== hdl/srle_div.sv =====
module srle_div
  import srle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [TICK_W-1:0] divisor,
  output logic              done,
  output logic [ACC_W-1:0]  quotient,
  output logic [TICK_W-1:0] remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0]     q_r, q_nxt;
  logic [TICK_W-1:0]    rem_r, rem_nxt;
  logic [TICK_W-1:0]    den_r, den_nxt;
  logic [TICK_W:0]      trial;
  logic [TICK_W+1:0]    diff;
  logic                 ge;

  assign trial = {rem_r, q_r[ACC_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[TICK_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(ACC_W - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[ACC_W-2:0], ge};
      rem_nxt = ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/sound_register_log_encoder.sv =====
// Sound register log encoder.
// Input items (in_*): tuser holds the request type (write, wait, end);
// tdata holds device, register address, register value and wait time.
// A wait item is added into a saturating microsecond accumulator and
// produces no output. A write or end item runs a one-bit-per-cycle
// restoring divider that divides the accumulator by the tick length, then
// emits one byte per cycle on out_* while out_tready is high: optional
// sync bytes (0xFF, or 0xFE plus 7-bit count groups), then either three
// register-write bytes or 0xFD. out_tlast marks the final byte of an item.
// A write or end item emits at most 9 bytes, and in_tready is high only
// while the sequencer is idle.
// The output register holds a byte while out_tready is low and the
// sequencer waits; a new item may be taken while the last byte still waits.
// cfg_data sets the tick length in microseconds (0 acts as 1); cfg_ready
// is always high. Reset clears the accumulator, sets the tick to 10000 us
// and empties the output register.
module sound_register_log_encoder
  import srle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [5:0] device, [14:6] reg_address, [22:15] reg_value, [46:23] wait_us
  input  logic [IN_DATA_W-1:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] out_byte
  output logic [BYTE_W-1:0]    out_tdata,
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TICK_W-1:0]    cfg_data
);

  state_t              state_r, state_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  req_t                type_r, type_nxt;
  logic [DEV_W-1:0]    device_r, device_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [VAL_W-1:0]    value_r, value_nxt;
  logic [ACC_W-1:0]    rest_r, rest_nxt;
  logic                one_r, one_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  req_t                in_type;
  logic                in_fire;
  logic                div_start;
  logic                div_done;
  logic [ACC_W-1:0]    div_quot;
  logic [TICK_W-1:0]   div_rem;
  logic [TICK_W-1:0]   tick_eff;
  logic [ACC_W:0]      wait_sum;
  logic [ACC_W-1:0]    rest_shift;
  logic                grp_more;
  logic                out_free;
  logic                emit;
  logic [BYTE_W-1:0]   byte_c;
  logic                last_c;
  logic                load;
  state_t              payload_state;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_type    = req_t'(in_tuser);
  assign in_fire    = in_tvalid & in_tready;
  assign div_start  = in_fire & ((in_type == REQ_WRITE) | (in_type == REQ_END));
  assign tick_eff   = (tick_r == '0) ? TICK_W'(1) : tick_r;
  assign wait_sum   = {1'b0, acc_r} + {{(ACC_W+1-WAIT_W){1'b0}}, in_tdata[46:23]};
  assign rest_shift = rest_r >> GRP_W;
  assign grp_more   = (rest_shift != '0);
  assign out_free   = ~out_valid_r | out_tready;
  assign load       = emit & out_free;
  assign payload_state = (type_r == REQ_END) ? ST_END : ST_DEV;

  srle_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (acc_r),
    .divisor   (tick_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (div_start) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = (div_quot == '0) ? payload_state : ST_SYNC_HEAD;
      end
      ST_SYNC_HEAD: begin
        if (out_free) state_nxt = one_r ? payload_state : ST_SYNC_GRP;
      end
      ST_SYNC_GRP: begin
        if (out_free && !grp_more) state_nxt = payload_state;
      end
      ST_DEV: begin
        if (out_free) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (out_free) state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_END: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // byte selection
  always_comb begin
    emit   = 1'b0;
    byte_c = '0;
    last_c = 1'b0;
    case (state_r)
      ST_SYNC_HEAD: begin
        emit   = 1'b1;
        byte_c = one_r ? SYNC_ONE : SYNC_MANY;
      end
      ST_SYNC_GRP: begin
        emit   = 1'b1;
        byte_c = {grp_more, rest_r[GRP_W-1:0]};
      end
      ST_DEV: begin
        emit   = 1'b1;
        byte_c = {1'b0, device_r, addr_r[ADDR_W-1]};
      end
      ST_ADDR: begin
        emit   = 1'b1;
        byte_c = addr_r[BYTE_W-1:0];
      end
      ST_DATA: begin
        emit   = 1'b1;
        byte_c = value_r;
        last_c = 1'b1;
      end
      ST_END: begin
        emit   = 1'b1;
        byte_c = END_CODE;
        last_c = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    acc_nxt       = acc_r;
    tick_nxt      = tick_r;
    type_nxt      = type_r;
    device_nxt    = device_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    rest_nxt      = rest_r;
    one_nxt       = one_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid) tick_nxt = cfg_data;

    if (in_fire) begin
      type_nxt   = in_type;
      device_nxt = in_tdata[5:0];
      addr_nxt   = in_tdata[14:6];
      value_nxt  = in_tdata[22:15];
      if (in_type == REQ_WAIT) acc_nxt = wait_sum[ACC_W] ? ACC_MAX : wait_sum[ACC_W-1:0];
    end

    if (div_done) begin
      acc_nxt  = {{(ACC_W-TICK_W){1'b0}}, div_rem};
      rest_nxt = div_quot - ACC_W'(2);
      one_nxt  = (div_quot == ACC_W'(1));
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_c;
      out_last_nxt  = last_c;
      if (state_r == ST_SYNC_GRP) rest_nxt = rest_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      tick_r      <= TICK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r     <= type_nxt;
    device_r   <= device_nxt;
    addr_r     <= addr_nxt;
    value_r    <= value_nxt;
    rest_r     <= rest_nxt;
    one_r      <= one_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider result outside divide state");

  a_rem_below_tick: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> (acc_r < {{(ACC_W-TICK_W){1'b0}}, tick_eff}))
    else $error("accumulator remainder not below tick");

  a_wait_no_decrease: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_type == REQ_WAIT)) |=> (acc_r >= $past(acc_r)))
    else $error("accumulator decreased on wait item");

endmodule

// ===== tb/sv/sound_register_log_encoder_tb.sv =====
`timescale 1ns / 100ps

module sound_register_log_encoder_tb
  import srle_pkg::*;
();

  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  class log_stream_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
    } log_byte_t;

    logic [TICK_W-1:0] tick_us;
    logic [ACC_W-1:0]  pending_us;
    log_byte_t         expected_bytes[$];
    int                errors;

    function new();
      tick_us    = TICK_RESET;
      pending_us = '0;
      errors     = 0;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] b, logic last);
      log_byte_t e;
      e.data = b;
      e.last = last;
      expected_bytes.push_back(e);
    endfunction

    function void flush_ticks();
      logic [ACC_W-1:0] t;
      logic [ACC_W-1:0] n;
      logic [ACC_W-1:0] rest;
      t = (tick_us == '0) ? ACC_W'(1) : ACC_W'(tick_us);
      if (pending_us < t) return;
      n = pending_us / t;
      pending_us = pending_us % t;
      if (n == ACC_W'(1)) begin
        push_byte(SYNC_ONE, 1'b0);
      end else begin
        push_byte(SYNC_MANY, 1'b0);
        rest = n - ACC_W'(2);
        while (rest >= ACC_W'(128)) begin
          push_byte({1'b1, rest[GRP_W-1:0]}, 1'b0);
          rest = rest >> GRP_W;
        end
        push_byte({1'b0, rest[GRP_W-1:0]}, 1'b0);
      end
    endfunction

    function void note_request(logic [1:0] req, logic [IN_DATA_W-1:0] d);
      logic [DEV_W-1:0]  dev;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  val;
      logic [WAIT_W-1:0] wait_us;
      logic [ACC_W:0]    sum;
      dev     = d[5:0];
      addr    = d[14:6];
      val     = d[22:15];
      wait_us = d[46:23];
      case (req)
        REQ_WAIT: begin
          sum = {1'b0, pending_us} + (ACC_W+1)'(wait_us);
          pending_us = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
        REQ_WRITE: begin
          flush_ticks();
          push_byte({1'b0, dev, addr[ADDR_W-1]}, 1'b0);
          push_byte(addr[BYTE_W-1:0], 1'b0);
          push_byte(val, 1'b1);
        end
        REQ_END: begin
          flush_ticks();
          push_byte(END_CODE, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [BYTE_W-1:0] b, logic last);
      log_byte_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", b, last));
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.data)
          report_mismatch($sformatf("byte %02h, expected %02h", b, e.data));
        if (last !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b (byte %02h)", last, e.last,
                                    e.data));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]           in_tuser = REQ_WRITE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_W-1:0]    out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [TICK_W-1:0]    cfg_data = '0;

  log_stream_scoreboard sb;
  int                   send_idle = 0;
  int                   recv_stall = 0;
  logic                 hold = 1'b0;
  int                   quiet_cycles = 0;

  sound_register_log_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= !hold && (recv_stall == 0 || $urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(logic [DEV_W-1:0] dev,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [VAL_W-1:0] val,
                                                     logic [WAIT_W-1:0] wait_us);
    return {1'b0, wait_us, val, addr, dev};
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = 0;
    while (send_idle != 0 && $urandom_range(99) < send_idle) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, d);
  endtask

  task automatic drain_results();
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick(input logic [TICK_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.tick_us = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= TICK_W'($urandom());
  endtask

  task automatic run_random(input int count);
    logic [1:0]  req;
    int unsigned r;
    int unsigned t;
    int unsigned w;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      req = (r < 45) ? REQ_WRITE : (r < 80) ? REQ_WAIT : (r < 92) ? REQ_END : REQ_UNUSED;
      t = (sb.tick_us == '0) ? 1 : int'(sb.tick_us);
      case ($urandom_range(3))
        0:       w = $urandom_range(t);
        1:       w = $urandom_range(3 * t);
        2:       w = $urandom();
        default: w = $urandom_range(1) ? 32'hFF_FFFF : 0;
      endcase
      send_item(req, pack_item(DEV_W'($urandom()), ADDR_W'($urandom()),
                               VAL_W'($urandom()), WAIT_W'(w)));
    end
  endtask

  logic [TICK_W-1:0] phase_tick[6] = '{20'd1, 20'd0, 20'd37, 20'd10000, 20'd1000000,
                                       20'hFFFFF};
  int idle_plan[4]  = '{0, 47, 0, 38};
  int stall_plan[4] = '{0, 0, 47, 38};

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset tick length: no pending time, banks, sync forms, group boundaries
    send_item(REQ_WRITE,  pack_item(6'd0, 9'd0, 8'd0, 24'd0));
    send_item(REQ_WRITE,  pack_item(6'd63, 9'd511, 8'd255, 24'hFFFFFF));
    send_item(REQ_WRITE,  pack_item(6'd21, 9'h155, 8'hAA, 24'h555555));
    send_item(REQ_WRITE,  pack_item(6'd42, 9'h0AA, 8'h55, 24'hAAAAAA));
    send_item(REQ_WAIT,   pack_item(6'd63, 9'd511, 8'd255, 24'd10000));
    send_item(REQ_WRITE,  pack_item(6'd1, 9'd256, 8'd1, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd20000));
    send_item(REQ_END,    pack_item(6'd63, 9'd511, 8'd255, 24'hFFFFFF));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd9999));
    send_item(REQ_END,    pack_item(6'd0, 9'd0, 8'd0, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd1));
    send_item(REQ_WRITE,  pack_item(6'd5, 9'd300, 8'd77, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'hFFFFFF));
    send_item(REQ_UNUSED, pack_item(6'd63, 9'd511, 8'd255, 24'hFFFFFF));
    send_item(REQ_WRITE,  pack_item(6'd9, 9'd18, 8'd200, 24'd0));
    send_item(REQ_UNUSED, pack_item(6'd0, 9'd0, 8'd0, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd0));
    send_item(REQ_END,    pack_item(6'd0, 9'd0, 8'd0, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd1290000));
    send_item(REQ_WRITE,  pack_item(6'd30, 9'd128, 8'd128, 24'd0));
    send_item(REQ_WAIT,   pack_item(6'd0, 9'd0, 8'd0, 24'd1300000));
    send_item(REQ_END,    pack_item(6'd0, 9'd0, 8'd0, 24'd0));

    // zero tick acts as one; saturate the accumulator for the longest count
    write_tick(20'd0);
    repeat (257) send_item(REQ_WAIT, pack_item(DEV_W'($urandom()), ADDR_W'($urandom()),
                                               VAL_W'($urandom()), 24'hFFFFFF));
    send_item(REQ_WRITE, pack_item(6'd63, 9'd511, 8'd255, 24'd0));
    send_item(REQ_END,   pack_item(6'd0, 9'd0, 8'd0, 24'd0));

    for (int p = 0; p < 6; p++) begin
      send_idle  = idle_plan[p % 4];
      recv_stall = stall_plan[p % 4];
      write_tick(phase_tick[p]);
      if (p == 0) begin
        fork
          begin
            hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold = 1'b0;
          end
        join_none
      end
      run_random(6);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_results();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
